// ===== src/rtpb_pkg.sv =====
`timescale 1ns / 1ps

package rtpb_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int STAGE_W       = $clog2(TABLE_LEN);

  // Angle arithmetic, radians in Q.24.
  localparam int ANG_W   = 28;
  localparam int NUM_W   = 41;
  localparam int CNT_W   = $clog2(NUM_W + 1);

  localparam logic [25:0]        ANG_K314    = 26'd52680458;
  localparam logic [ANG_W-1:0]   ANG_PI      = 28'd52707178;
  localparam logic [ANG_W-1:0]   ANG_TWO_PI  = 28'd105414357;
  localparam logic [ANG_W-1:0]   ANG_HALF_PI = 28'd26353589;
  localparam logic [ANG_W-1:0]   CORDIC_GAIN = 28'd10188014;

  // Reduction modulo two pi: the quotient by two pi is estimated from the
  // upper dividend bits times floor(2^40 / two pi); the estimate is low by at
  // most one, so a single compare and subtract finishes the remainder.
  localparam int                 MOD_SHIFT        = 20;
  localparam logic [13:0]        ANG_TWO_PI_RECIP = 14'd10430;

  // Configuration register indexes.
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_SCALE    = 3'd2;
  localparam logic [2:0] REG_OFFSET_X = 3'd3;
  localparam logic [2:0] REG_OFFSET_Y = 3'd4;
  localparam logic [2:0] REG_ROTATION = 3'd5;

  // Operation kinds.
  localparam logic [1:0] KIND_FWD = 2'd0;
  localparam logic [1:0] KIND_INV = 2'd1;
  localparam logic [1:0] KIND_BOX = 2'd2;

  localparam int NUM_LANES = 4;

  typedef struct packed {
    logic               busy;
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
  } trig_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

  function automatic logic [ANG_W-1:0] atan_q24(input logic [STAGE_W-1:0] idx);
    logic [ANG_W-1:0] r;
    case (idx)
      5'd0:    r = 28'd13176795;
      5'd1:    r = 28'd7778716;
      5'd2:    r = 28'd4110060;
      5'd3:    r = 28'd2086331;
      5'd4:    r = 28'd1047214;
      5'd5:    r = 28'd524117;
      5'd6:    r = 28'd262123;
      5'd7:    r = 28'd131069;
      default: r = ANG_W'(28'd65536 >> (idx - 5'd8));
    endcase
    return r;
  endfunction

endpackage

// ===== src/rtpb_sincos.sv =====
`timescale 1ns / 1ps

module rtpb_sincos (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        restart_i,
  input  logic [15:0] scale_i,
  input  logic [15:0] rotation_i,
  output rtpb_pkg::trig_t trig_o
);

  localparam logic [3:0] S_MUL   = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_EST   = 4'd2;
  localparam logic [3:0] S_SUB   = 4'd3;
  localparam logic [3:0] S_FIX   = 4'd4;
  localparam logic [3:0] S_FOLD  = 4'd5;
  localparam logic [3:0] S_CORD  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_READY = 4'd8;

  localparam int W = rtpb_pkg::ANG_W;

  logic [3:0]                     state_q, state_d;
  logic [rtpb_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [rtpb_pkg::NUM_W-1:0]     num_q, num_d;
  logic [W-1:0]                   rem_q, rem_d;
  logic [14:0]                    k_q, k_d;
  logic                           neg_q, neg_d;
  logic                           flip_q, flip_d;
  logic signed [W-1:0]            x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [15:0]             cos_q, cos_d, sin_q, sin_d;

  logic signed [42:0]             prod;
  logic [15:0]                    divisor;
  logic [16:0]                    drem;
  logic                           dge;
  logic [34:0]                    kest;
  logic [rtpb_pkg::NUM_W-1:0]     kmul;
  logic signed [W:0]              ang_a, ang_b;
  logic signed [W-1:0]            ysh, xsh;
  logic [rtpb_pkg::STAGE_W-1:0]   stage;
  logic signed [W-1:0]            xf, yf;

  function automatic logic signed [15:0] to_q14(input logic signed [W-1:0] v);
    logic signed [W-1:0] t;
    t = (v + W'(512)) >>> 10;
    if (t > W'(16384)) return 16'sd16384;
    if (t < -W'(16384)) return -16'sd16384;
    return t[15:0];
  endfunction

  assign divisor = (scale_i == 16'd0) ? 16'd1 : scale_i;
  assign prod    = 43'($signed(rotation_i)) * $signed({17'd0, rtpb_pkg::ANG_K314});
  assign drem    = {rem_q[15:0], num_q[rtpb_pkg::NUM_W-1]};
  assign dge     = drem >= {1'b0, divisor};
  assign kest    = 35'(num_q[rtpb_pkg::NUM_W-1:rtpb_pkg::MOD_SHIFT]) *
                   35'(rtpb_pkg::ANG_TWO_PI_RECIP);
  assign kmul    = rtpb_pkg::NUM_W'(k_q) * rtpb_pkg::NUM_W'(rtpb_pkg::ANG_TWO_PI);
  assign stage   = cnt_q[rtpb_pkg::STAGE_W-1:0];
  assign ysh     = y_q >>> stage;
  assign xsh     = x_q >>> stage;
  assign xf      = flip_q ? -x_q : x_q;
  assign yf      = flip_q ? -y_q : y_q;

  always_comb begin
    // Truncated remainder takes the dividend sign; then map into (-pi, pi].
    if (neg_q && rem_q != '0) begin
      ang_a = $signed({1'b0, rtpb_pkg::ANG_TWO_PI - rem_q});
    end else begin
      ang_a = $signed({1'b0, rem_q});
    end
    if (ang_a > $signed({1'b0, rtpb_pkg::ANG_PI})) begin
      ang_b = ang_a - $signed({1'b0, rtpb_pkg::ANG_TWO_PI});
    end else begin
      ang_b = ang_a;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    k_d     = k_q;
    neg_d   = neg_q;
    flip_d  = flip_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    cos_d   = cos_q;
    sin_d   = sin_q;
    unique case (state_q)
      S_MUL: begin
        neg_d   = prod[42];
        num_d   = prod[42] ? rtpb_pkg::NUM_W'(-prod) : rtpb_pkg::NUM_W'(prod);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = W'(dge ? drem - {1'b0, divisor} : drem);
        num_d = {num_q[rtpb_pkg::NUM_W-2:0], dge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == rtpb_pkg::CNT_W'(rtpb_pkg::NUM_W - 1)) begin
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_EST;
        end
      end
      S_EST: begin
        k_d     = kest[34:rtpb_pkg::MOD_SHIFT];
        state_d = S_SUB;
      end
      S_SUB: begin
        rem_d   = W'(num_q - kmul);
        state_d = S_FIX;
      end
      S_FIX: begin
        if (rem_q >= rtpb_pkg::ANG_TWO_PI) begin
          rem_d = rem_q - rtpb_pkg::ANG_TWO_PI;
        end
        state_d = S_FOLD;
      end
      S_FOLD: begin
        x_d    = $signed(rtpb_pkg::CORDIC_GAIN);
        y_d    = '0;
        cnt_d  = '0;
        flip_d = 1'b0;
        if (ang_b > $signed({1'b0, rtpb_pkg::ANG_HALF_PI})) begin
          z_d    = W'(ang_b - $signed({1'b0, rtpb_pkg::ANG_PI}));
          flip_d = 1'b1;
        end else if (ang_b < -$signed({1'b0, rtpb_pkg::ANG_HALF_PI})) begin
          z_d    = W'(ang_b + $signed({1'b0, rtpb_pkg::ANG_PI}));
          flip_d = 1'b1;
        end else begin
          z_d = W'(ang_b);
        end
        state_d = S_CORD;
      end
      S_CORD: begin
        if (!z_q[W-1]) begin
          x_d = x_q - ysh;
          y_d = y_q + xsh;
          z_d = z_q - $signed(rtpb_pkg::atan_q24(stage));
        end else begin
          x_d = x_q + ysh;
          y_d = y_q - xsh;
          z_d = z_q + $signed(rtpb_pkg::atan_q24(stage));
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == rtpb_pkg::CNT_W'(rtpb_pkg::NUM_STAGES - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        cos_d   = to_q14(xf);
        sin_d   = to_q14(yf);
        state_d = S_READY;
      end
      S_READY: begin
      end
      default: state_d = S_MUL;
    endcase
    if (restart_i) begin
      state_d = S_MUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_MUL;
      cnt_q   <= '0;
      cos_q   <= 16'sd16384;
      sin_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cos_q   <= cos_d;
      sin_q   <= sin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    k_q    <= k_d;
    neg_q  <= neg_d;
    flip_q <= flip_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign trig_o.busy  = state_q != S_READY;
  assign trig_o.cos_v = cos_q;
  assign trig_o.sin_v = sin_q;

endmodule

// ===== src/rtpb_lane.sv =====
`timescale 1ns / 1ps

module rtpb_lane (
  input  logic               clk_i,
  input  rtpb_pkg::point_t   pt_i,
  input  rtpb_pkg::point_t   pivot_i,
  input  rtpb_pkg::point_t   dst_i,
  input  logic signed [15:0] cos_i,
  input  logic signed [15:0] sin_i,
  output rtpb_pkg::point_t   pt_o
);

  logic signed [16:0] dx_q, dy_q;
  logic signed [32:0] cx_q, sx_q, cy_q, sy_q;
  rtpb_pkg::point_t   dst1_q, dst2_q, pt_q, pt_d;
  logic signed [33:0] rx, ry;
  logic signed [19:0] rxr, ryr;
  logic signed [20:0] ox, oy;

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    if (v > 21'sd32767) return 16'sh7fff;
    if (v < -21'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  assign rx  = 34'(cx_q) - 34'(sy_q);
  assign ry  = 34'(sx_q) + 34'(cy_q);
  assign rxr = 20'((rx + 34'sd8192) >>> 14);
  assign ryr = 20'((ry + 34'sd8192) >>> 14);
  assign ox  = 21'(rxr) + 21'(dst2_q.x);
  assign oy  = 21'(ryr) + 21'(dst2_q.y);

  always_comb begin
    pt_d.x = sat16(ox);
    pt_d.y = sat16(oy);
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= 17'(pt_i.x) - 17'(pivot_i.x);
    dy_q   <= 17'(pt_i.y) - 17'(pivot_i.y);
    dst1_q <= dst_i;
    cx_q   <= 33'(cos_i) * 33'(dx_q);
    sx_q   <= 33'(sin_i) * 33'(dx_q);
    cy_q   <= 33'(cos_i) * 33'(dy_q);
    sy_q   <= 33'(sin_i) * 33'(dy_q);
    dst2_q <= dst1_q;
    pt_q   <= pt_d;
  end

  assign pt_o = pt_q;

endmodule

// ===== src/rtpb_merge.sv =====
`timescale 1ns / 1ps

module rtpb_merge (
  input  logic             clk_i,
  input  rtpb_pkg::point_t lane_i [rtpb_pkg::NUM_LANES],
  input  logic             box_i,
  output rtpb_pkg::point_t min_o,
  output rtpb_pkg::point_t max_o
);

  rtpb_pkg::point_t min_d, max_d, min_q, max_q;

  always_comb begin
    min_d = lane_i[0];
    max_d = lane_i[0];
    if (box_i) begin
      for (int k = 1; k < rtpb_pkg::NUM_LANES; k++) begin
        if (lane_i[k].x < min_d.x) min_d.x = lane_i[k].x;
        if (lane_i[k].y < min_d.y) min_d.y = lane_i[k].y;
        if (lane_i[k].x > max_d.x) max_d.x = lane_i[k].x;
        if (lane_i[k].y > max_d.y) max_d.y = lane_i[k].y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    max_q <= max_d;
  end

  assign min_o = min_q;
  assign max_o = max_q;

endmodule

// ===== src/rigid_transform_point_and_box_top.sv =====
`timescale 1ns / 1ps

// Rotates and translates points and boxes in signed Q12.4 coordinates. After
// reset and after every configuration write, busy_o stays high while a serial
// unit works out sine and cosine from the configured rotation (one multiply,
// a 41-step divider, a three-step reduction modulo two pi, one quadrant fold,
// 16 CORDIC steps and one rounding step); no beat is taken in that time.
// Once busy_o is low, one beat is accepted in every cycle that start_i is
// high, and its result appears after the lane register stages and the merge
// register, with valid_o high for exactly one cycle. The receiver cannot
// stall the block, so results must be taken as they come. Four lanes each
// transform one corner of the beat; for a box the merge stage returns the
// minimum and maximum, for a point lane zero alone is used and its result is
// repeated on both output pairs. Write configuration only while no beat is
// in flight. Results saturate to the 16-bit range.
module rigid_transform_point_and_box_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic signed [15:0] in_x0_i,
  input  logic signed [15:0] in_y0_i,
  input  logic signed [15:0] in_x1_i,
  input  logic signed [15:0] in_y1_i,
  output logic        valid_o,
  output logic signed [15:0] out_x0_o,
  output logic signed [15:0] out_y0_o,
  output logic signed [15:0] out_x1_o,
  output logic signed [15:0] out_y1_o
);

  // Configuration registers.
  logic signed [15:0] center_x_q, center_y_q, offset_x_q, offset_y_q;
  logic [15:0]        scale_q, rotation_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      scale_q    <= 16'd16;
      offset_x_q <= '0;
      offset_y_q <= '0;
      rotation_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rtpb_pkg::REG_CENTER_X: center_x_q <= cfg_wdata_i;
        rtpb_pkg::REG_CENTER_Y: center_y_q <= cfg_wdata_i;
        rtpb_pkg::REG_SCALE:    scale_q    <= cfg_wdata_i;
        rtpb_pkg::REG_OFFSET_X: offset_x_q <= cfg_wdata_i;
        rtpb_pkg::REG_OFFSET_Y: offset_y_q <= cfg_wdata_i;
        rtpb_pkg::REG_ROTATION: rotation_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Sine and cosine are recomputed whenever the configuration changes.
  rtpb_pkg::trig_t trig;

  rtpb_sincos u_sincos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (cfg_we_i),
    .scale_i    (scale_q),
    .rotation_i (rotation_q),
    .trig_o     (trig)
  );

  assign busy_o = trig.busy;

  logic accept;
  logic inv, box;
  assign accept = start_i && !trig.busy;
  assign inv    = kind_i == rtpb_pkg::KIND_INV;
  assign box    = kind_i == rtpb_pkg::KIND_BOX;

  // The inverse transform pivots on the offset, lands on the center and
  // rotates the other way.
  rtpb_pkg::point_t   pivot, dst;
  logic signed [15:0] sin_eff;
  rtpb_pkg::point_t   corner [rtpb_pkg::NUM_LANES];
  rtpb_pkg::point_t   lane_out [rtpb_pkg::NUM_LANES];

  always_comb begin
    pivot.x = inv ? offset_x_q : center_x_q;
    pivot.y = inv ? offset_y_q : center_y_q;
    dst.x   = inv ? center_x_q : offset_x_q;
    dst.y   = inv ? center_y_q : offset_y_q;
    sin_eff = inv ? -trig.sin_v : trig.sin_v;
    corner[0].x = in_x0_i;
    corner[0].y = in_y0_i;
    corner[1].x = in_x1_i;
    corner[1].y = in_y0_i;
    corner[2].x = in_x0_i;
    corner[2].y = in_y1_i;
    corner[3].x = in_x1_i;
    corner[3].y = in_y1_i;
  end

  // The sine sign must follow the beat into the multiply stage.
  logic signed [15:0] sin_s1_q;
  always_ff @(posedge clk_i) begin
    sin_s1_q <= sin_eff;
  end

  for (genvar g = 0; g < rtpb_pkg::NUM_LANES; g++) begin : g_lane
    rtpb_lane u_lane (
      .clk_i   (clk_i),
      .pt_i    (corner[g]),
      .pivot_i (pivot),
      .dst_i   (dst),
      .cos_i   (trig.cos_v),
      .sin_i   (sin_s1_q),
      .pt_o    (lane_out[g])
    );
  end

  // Valid and box flag travel alongside the three lane stages.
  logic [2:0] vld_q;
  logic [2:0] box_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      vld_q   <= {vld_q[1:0], accept};
      valid_o <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    box_q <= {box_q[1:0], box};
  end

  rtpb_pkg::point_t min_pt, max_pt;

  rtpb_merge u_merge (
    .clk_i  (clk_i),
    .lane_i (lane_out),
    .box_i  (box_q[2]),
    .min_o  (min_pt),
    .max_o  (max_pt)
  );

  assign out_x0_o = min_pt.x;
  assign out_y0_o = min_pt.y;
  assign out_x1_o = max_pt.x;
  assign out_y1_o = max_pt.y;

endmodule

// ===== src/rtpb_checker.sv =====
`timescale 1ns / 1ps

module rtpb_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        start_i,
  input logic        busy_o,
  input logic [1:0]  kind_i,
  input logic        valid_o,
  input logic signed [15:0] out_x0_o,
  input logic signed [15:0] out_y0_o,
  input logic signed [15:0] out_x1_o,
  input logic signed [15:0] out_y1_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##4 valid_o)
    else $error("accepted beat gave no result after four cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, 4))
    else $error("result without an accepted beat");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy_o)
    else $error("configuration write did not start recompute");

  a_point_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(kind_i != rtpb_pkg::KIND_BOX, 4)
    |-> out_x1_o == out_x0_o && out_y1_o == out_y0_o)
    else $error("point result pairs differ");

  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> out_x0_o <= out_x1_o && out_y0_o <= out_y1_o)
    else $error("box minimum above maximum");

endmodule

bind rigid_transform_point_and_box_top rtpb_props u_rtpb_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .cfg_we_i (cfg_we_i),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .kind_i   (kind_i),
  .valid_o  (valid_o),
  .out_x0_o (out_x0_o),
  .out_y0_o (out_y0_o),
  .out_x1_o (out_x1_o),
  .out_y1_o (out_y1_o)
);

// ===== verif/rtpb_checker.sv =====
`timescale 1ns / 1ps

module rtpb_checker
  import rtpb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic [1:0]         kind_i,
  input  logic signed [15:0] in_x0_i,
  input  logic signed [15:0] in_y0_i,
  input  logic signed [15:0] in_x1_i,
  input  logic signed [15:0] in_y1_i,
  input  logic               valid_o,
  input  logic signed [15:0] out_x0_o,
  input  logic signed [15:0] out_y0_o,
  input  logic signed [15:0] out_x1_o,
  input  logic signed [15:0] out_y1_o,
  output int                 errors_o,
  output int                 pending_o
);

  typedef struct {
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
  } box_t;

  logic signed [15:0] ctr_x, ctr_y, off_x, off_y, rot;
  logic [15:0]        scale;
  box_t               expected_boxes[$];

  localparam longint ATAN_TAB[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint to_q14(longint v);
    longint r;
    r = (v + 512) >>> 10;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void sin_cos(output longint c, output longint s);
    longint div, a, x, y, nx;
    bit     neg;
    div = (scale == 16'd0) ? 1 : longint'(scale);
    a = (longint'(rot) * 52680458) / div;
    x = 10188014;
    y = 0;
    neg = 0;
    a = a % 105414357;
    if (a < 0) a += 105414357;
    if (a > 52707178) a -= 105414357;
    if (a > 26353589) begin
      a -= 52707178;
      neg = 1;
    end else if (a < -26353589) begin
      a += 52707178;
      neg = 1;
    end
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        a -= ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        a += ATAN_TAB[i];
      end
      x = nx;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = to_q14(x);
    s = to_q14(y);
  endfunction

  function automatic void rotate_about(longint px, longint py, longint pvx, longint pvy,
                                       longint dsx, longint dsy, longint c, longint s,
                                       output longint ox, output longint oy);
    longint dx, dy;
    dx = px - pvx;
    dy = py - pvy;
    ox = clamp16(dsx + ((c * dx - s * dy + 8192) >>> 14));
    oy = clamp16(dsy + ((s * dx + c * dy + 8192) >>> 14));
  endfunction

  function automatic box_t transform_beat(logic [1:0] kind, longint x0, longint y0,
                                          longint x1, longint y1);
    box_t   r;
    longint c, s, tx, ty, mnx, mny, mxx, mxy;
    longint cxs[4], cys[4];
    sin_cos(c, s);
    if (kind == KIND_BOX) begin
      cxs = '{x0, x1, x0, x1};
      cys = '{y0, y0, y1, y1};
      mnx = 32767; mny = 32767; mxx = -32768; mxy = -32768;
      for (int k = 0; k < 4; k++) begin
        rotate_about(cxs[k], cys[k], ctr_x, ctr_y, off_x, off_y, c, s, tx, ty);
        if (tx < mnx) mnx = tx;
        if (ty < mny) mny = ty;
        if (tx > mxx) mxx = tx;
        if (ty > mxy) mxy = ty;
      end
    end else begin
      if (kind == KIND_INV)
        rotate_about(x0, y0, off_x, off_y, ctr_x, ctr_y, c, -s, tx, ty);
      else
        rotate_about(x0, y0, ctr_x, ctr_y, off_x, off_y, c, s, tx, ty);
      mnx = tx; mxx = tx; mny = ty; mxy = ty;
    end
    r.x0 = mnx[15:0]; r.y0 = mny[15:0]; r.x1 = mxx[15:0]; r.y1 = mxy[15:0];
    return r;
  endfunction

  assign pending_o = expected_boxes.size();

  always @(posedge clk_i or negedge rst_ni) begin
    box_t exp_box;
    if (!rst_ni) begin
      ctr_x = '0; ctr_y = '0; off_x = '0; off_y = '0; rot = '0;
      scale = 16'd16;
      expected_boxes.delete();
      errors_o = 0;
    end else begin
      if (valid_o) begin
        if (expected_boxes.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: result beat with nothing expected: %0d %0d %0d %0d", $time,
                     out_x0_o, out_y0_o, out_x1_o, out_y1_o);
        end else begin
          exp_box = expected_boxes.pop_front();
          if (exp_box.x0 !== out_x0_o || exp_box.y0 !== out_y0_o ||
              exp_box.x1 !== out_x1_o || exp_box.y1 !== out_y1_o) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: mismatch, expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                       $time, exp_box.x0, exp_box.y0, exp_box.x1, exp_box.y1,
                       out_x0_o, out_y0_o, out_x1_o, out_y1_o);
          end
        end
      end
      // Register writes must land only while idle; the block does not enforce it.
      if (start_i && !busy_o)
        expected_boxes.push_back(transform_beat(kind_i, in_x0_i, in_y0_i,
                                                in_x1_i, in_y1_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CENTER_X: ctr_x = cfg_wdata_i;
          REG_CENTER_Y: ctr_y = cfg_wdata_i;
          REG_SCALE:    scale = cfg_wdata_i;
          REG_OFFSET_X: off_x = cfg_wdata_i;
          REG_OFFSET_Y: off_y = cfg_wdata_i;
          REG_ROTATION: rot   = cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== verif/tb_rigid_transform_point_and_box_top.sv =====
`timescale 1ns / 1ps

module tb_rigid_transform_point_and_box_top;
  import rtpb_pkg::*;

  // Index past the last register; a write there must change nothing.
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int         IDLE_LIMIT = 3000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_wdata_i = '0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         kind_i = '0;
  logic signed [15:0] in_x0_i = '0, in_y0_i = '0, in_x1_i = '0, in_y1_i = '0;
  logic               valid_o;
  logic signed [15:0] out_x0_o, out_y0_o, out_x1_o, out_y1_o;
  int                 errors, pending;
  int                 idle_pct;
  int                 quiet_cycles;

  rigid_transform_point_and_box_top dut (.*);

  rtpb_checker checker_i (.*, .errors_o(errors), .pending_o(pending));

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // The watchdog counts cycles in which neither a beat nor a result moves.
  // The limit is generous enough for the busy time after each register write
  // plus the longest sender gap.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("rigid_transform_point_and_box_top test failed");
      $finish;
    end
  end

  // Waits until no result is outstanding, then lets the pipeline drain.
  task automatic drain();
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // Registers are only touched while no beat is in flight.
  task automatic configure(logic [15:0] cx, logic [15:0] cy, logic [15:0] sc,
                           logic [15:0] ox, logic [15:0] oy, logic [15:0] rt);
    drain();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_SCALE, sc);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_ROTATION, rt);
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Idles the sender for a random number of cycles, each with the current
  // idle percentage, then presents one beat and holds it until the block
  // takes it.
  task automatic send_beat(logic [1:0] kind, logic [15:0] x0, logic [15:0] y0,
                           logic [15:0] x1, logic [15:0] y1);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    kind_i  <= kind;
    in_x0_i <= x0; in_y0_i <= y0; in_x1_i <= x1; in_y1_i <= y1;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Half of the coordinates span the whole range, the rest stay near the
  // origin so that results are not mostly saturated.
  function automatic logic [15:0] rand_coord();
    if ($urandom_range(1)) return 16'($urandom);
    return 16'($signed($urandom_range(0, 4095)) - 2048);
  endfunction

  task automatic random_beats(int count);
    logic [1:0] kind;
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(19) == 0) ? KIND_SPARE : 2'($urandom_range(2));
      send_beat(kind, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    idle_pct = 19;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at reset settings, then with a real rotation: field
    // extremes, every kind, the spare kind, and a box given with its corners
    // swapped.
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) configure(16'h0100, 16'hff00, 16'd64, 16'h0040, 16'hffc0, 16'd9);
      send_beat(KIND_FWD, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
      send_beat(KIND_FWD, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      send_beat(KIND_INV, 16'h7fff, 16'h7fff, 16'h1234, 16'h4321);
      send_beat(KIND_INV, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
      send_beat(KIND_BOX, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
      send_beat(KIND_BOX, 16'h0200, 16'h0300, 16'hfe00, 16'hfd00);
      send_beat(KIND_BOX, 16'h0010, 16'h0010, 16'h0010, 16'h0010);
      send_beat(KIND_SPARE, 16'h0123, 16'hfedc, 16'hffff, 16'hffff);
      send_beat(KIND_FWD, 16'hffff, 16'h0001, 16'h0000, 16'h0000);
    end

    // Random phases over several settings, extremes among them: a zero
    // scale, the smallest and largest scale, and the largest rotations.
    configure(16'h7fff, 16'h8000, 16'd0, 16'h8000, 16'h7fff, 16'd3);
    random_beats(80);
    configure(16'h0000, 16'h0000, 16'd1, 16'h0000, 16'h0000, 16'h7fff);
    random_beats(80);
    configure(16'h8000, 16'h7fff, 16'hffff, 16'h7fff, 16'h8000, 16'h8000);
    random_beats(80);
    // Hold off here until every result is back before going on.
    drain();
    idle_pct = 57;
    configure(16'($urandom), 16'($urandom), 16'd16, 16'($urandom), 16'($urandom), 16'd8);
    random_beats(80);
    configure(16'h0020, 16'hffe0, 16'd100, 16'h0000, 16'h0040, 16'hffce);
    random_beats(80);
    configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
    random_beats(80);
    idle_pct = 0;
    configure(16'h0000, 16'h0000, 16'd2, 16'h0000, 16'h0000, 16'd1);
    random_beats(80);
    configure(16'($urandom_range(0, 512)), 16'($urandom_range(0, 512)),
              16'($urandom_range(1, 300)), 16'($urandom), 16'($urandom),
              16'($urandom));
    random_beats(80);

    drain();
    if (errors == 0)
      $display("rigid_transform_point_and_box_top test passed");
    else
      $display("rigid_transform_point_and_box_top test failed");
    $finish;
  end

endmodule

// ===== rigid_transform_point_and_box_top.f =====
src/rtpb_pkg.sv
src/rtpb_sincos.sv
src/rtpb_lane.sv
src/rtpb_merge.sv
src/rigid_transform_point_and_box_top.sv
src/rtpb_checker.sv
verif/rtpb_checker.sv
verif/tb_rigid_transform_point_and_box_top.sv
